/* sv/boosted_cascade_stage_evaluator_unit_macros.svh */
// Assertion helpers used by the top-level evaluator unit.
`ifndef BOOSTED_CASCADE_STAGE_EVALUATOR_UNIT_MACROS_SVH
`define BOOSTED_CASCADE_STAGE_EVALUATOR_UNIT_MACROS_SVH

`define BCSE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define BCSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/bcse_pkg.sv */
package bcse_pkg;

  localparam int unsigned MaxStages    = 64;
  localparam int unsigned AlphaEntries = 256;
  localparam int unsigned StageW       = $clog2(MaxStages);
  localparam int unsigned AlphaAddrW   = StageW + 8;
  localparam int unsigned CountW       = 7;
  localparam int unsigned RespW        = 24;
  localparam int unsigned QueueDepth   = 2;

  localparam logic [RespW-1:0] RespMax = 24'h7FFFFF;
  localparam logic [RespW-1:0] RespMin = 24'h800000;

  typedef enum logic [1:0] {
    OP_WR_ALPHA = 2'd0,
    OP_WR_STAGE = 2'd1,
    OP_EVAL     = 2'd2,
    OP_NOP      = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MODE_LBP  = 2'd0,
    MODE_LRD  = 2'd1,
    MODE_LRP  = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  localparam logic [1:0] CfgFeatureMode    = 2'd0;
  localparam logic [1:0] CfgStageCount     = 2'd1;
  localparam logic [1:0] CfgFinalThreshold = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic [5:0]         stage_index;
    logic [7:0]         entry_index;
    logic signed [15:0] table_value;
    logic [3:0]         rank_a;
    logic [3:0]         rank_b;
    logic [23:0]        row_top;
    logic [23:0]        row_mid;
    logic [23:0]        row_bottom;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         feature_code;
    logic signed [15:0] hypothesis;
    logic signed [23:0] response_sum;
    logic               rejected;
    logic               window_done;
    logic               detected;
    logic [6:0]         stages_done;
  } out_item_t;

  // front-end decoded work: one memory access and the window decision inputs
  typedef struct packed {
    op_e         op;
    logic [5:0]  stage;
    logic [7:0]  entry;
    logic [15:0] tval;
    logic [7:0]  ranks;
    logic [71:0] px;
  } work_t;

endpackage

/* sv/bcse_front.sv */
module bcse_front import bcse_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  output logic     full_o,
  input  in_item_t item_i,
  input  logic     q_full_i,
  output logic     q_push_o,
  output work_t    q_item_o
);

  // rank store is read as the item is registered; the register feeds the queue with ranks attached
  logic       v_q;
  in_item_t   it_q;
  logic       adv;
  logic       accept;
  logic [7:0] rank_mem [MaxStages];
  logic [7:0] rank_rdata_q;

  assign adv      = !v_q || !q_full_i;
  assign full_o   = !adv;
  assign accept   = push_i && adv;
  assign q_push_o = v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (adv) begin
      v_q <= push_i;
    end
  end

  // write ranks as the transaction is accepted so any later evaluation reads them
  always_ff @(posedge clk_i) begin
    if (adv) begin
      it_q         <= item_i;
      rank_rdata_q <= rank_mem[item_i.stage_index];
    end
    if (accept && op_e'(item_i.operation) == OP_WR_STAGE) begin
      rank_mem[item_i.stage_index] <= {item_i.rank_b, item_i.rank_a};
    end
  end

  always_comb begin
    q_item_o.op    = op_e'(it_q.operation);
    q_item_o.stage = it_q.stage_index;
    q_item_o.entry = it_q.entry_index;
    q_item_o.tval  = it_q.table_value;
    q_item_o.ranks = rank_rdata_q;
    q_item_o.px    = {it_q.row_bottom, it_q.row_mid, it_q.row_top};
  end

endmodule

/* sv/bcse_queue.sv */
module bcse_queue import bcse_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  work_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output work_t data_o
);

  work_t mem_q [QueueDepth];
  logic [$clog2(QueueDepth)-1:0] wp_q, rp_q;
  logic [$clog2(QueueDepth):0]   cnt_q;
  logic do_push, do_pop;

  assign full_o  = cnt_q == ($clog2(QueueDepth)+1)'(QueueDepth);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= wp_q + 1'b1;
      if (do_pop)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (do_push ? 1'b1 : 1'b0) - (do_pop ? 1'b1 : 1'b0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= data_i;
  end

endmodule

/* sv/bcse_feature.sv */
module bcse_feature import bcse_pkg::*; (
  input  mode_e       mode_i,
  input  logic [71:0] px_i,
  input  logic [7:0]  ranks_i,
  output logic [7:0]  code_o
);

  logic [7:0] p  [9];
  logic [7:0] sk [9];
  logic [3:0] ra, rb;
  logic [3:0] ca_s, cb_s, ca_u, cb_u;
  logic [7:0] lbp;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      p[i]  = px_i[8*i +: 8];
      sk[i] = px_i[8*i +: 8] ^ 8'h80;
    end
    ra = (ranks_i[3:0] > 4'd8) ? 4'd8 : ranks_i[3:0];
    rb = (ranks_i[7:4] > 4'd8) ? 4'd8 : ranks_i[7:4];
    ca_s = '0; cb_s = '0; ca_u = '0; cb_u = '0;
    for (int i = 0; i < 9; i++) begin
      ca_s = ca_s + {3'd0, sk[i] < sk[ra]};
      cb_s = cb_s + {3'd0, sk[i] < sk[rb]};
      ca_u = ca_u + {3'd0, p[i] < p[ra]};
      cb_u = cb_u + {3'd0, p[i] < p[rb]};
    end
    lbp = {sk[3] > sk[4], sk[6] > sk[4], sk[7] > sk[4], sk[8] > sk[4],
           sk[5] > sk[4], sk[2] > sk[4], sk[1] > sk[4], sk[0] > sk[4]};
    case (mode_i)
      MODE_LBP: code_o = lbp;
      MODE_LRD: code_o = 8'd8 + {4'd0, ca_s} - {4'd0, cb_s};
      MODE_LRP: code_o = {ca_u, cb_u};
      default:  code_o = 8'd0;
    endcase
  end

endmodule

/* sv/bcse_back.sv */
module bcse_back import bcse_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mode_e             mode_i,
  input  logic [CountW-1:0] num_stages_i,
  input  logic [RespW-1:0]  final_thr_i,
  input  logic              q_valid_i,
  input  work_t             q_item_i,
  output logic              q_pop_o,
  output logic              empty_o,
  input  logic              pop_i,
  output out_item_t         item_o
);

  logic [15:0] alpha_mem [MaxStages*AlphaEntries];
  logic [15:0] thr_mem   [MaxStages];

  // stage A: feature + alpha read; stage B: accumulate and register result
  logic        a_v_q;
  work_t       a_q;
  logic [7:0]  a_code_q;
  logic [15:0] a_alpha_q, a_thr_q;
  logic [7:0]  code;
  logic        a_adv, o_adv;
  logic        o_v_q;
  out_item_t   o_q;

  logic signed [RespW-1:0] resp_q, resp_d;
  logic                    rej_q, rej_d;
  logic [CountW-1:0]       cnt_q, cnt_d;
  logic [CountW-1:0]       n_eff;
  out_item_t               res;
  logic signed [RespW:0]   sum;
  logic signed [RespW-1:0] sat;
  logic signed [RespW-1:0] r0;
  logic                    rj0;
  logic [CountW-1:0]       c0;

  bcse_feature u_feat (
    .mode_i  (mode_i),
    .px_i    (q_item_i.px),
    .ranks_i (q_item_i.ranks),
    .code_o  (code)
  );

  assign o_adv   = !o_v_q || pop_i;
  assign a_adv   = !a_v_q || o_adv;
  assign q_pop_o = q_valid_i && a_adv;
  assign empty_o = !o_v_q;
  assign item_o  = o_q;

  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_item_i.op == OP_WR_ALPHA) begin
      alpha_mem[{q_item_i.stage[StageW-1:0], q_item_i.entry}] <= q_item_i.tval;
    end
    if (q_pop_o && q_item_i.op == OP_WR_STAGE) begin
      thr_mem[q_item_i.stage[StageW-1:0]] <= q_item_i.tval;
    end
    if (a_adv) begin
      a_q       <= q_item_i;
      a_code_q  <= code;
      a_alpha_q <= alpha_mem[{q_item_i.stage[StageW-1:0], code}];
      a_thr_q   <= thr_mem[q_item_i.stage[StageW-1:0]];
    end
    if (o_adv) o_q <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q  <= 1'b0;
      o_v_q  <= 1'b0;
      resp_q <= '0;
      rej_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (a_adv) a_v_q <= q_valid_i;
      if (o_adv) begin
        o_v_q <= a_v_q;
        if (a_v_q) begin
          resp_q <= resp_d;
          rej_q  <= rej_d;
          cnt_q  <= cnt_d;
        end
      end
    end
  end

  assign n_eff = (num_stages_i > CountW'(MaxStages)) ? CountW'(MaxStages) : num_stages_i;

  always_comb begin
    r0  = resp_q;
    rj0 = rej_q;
    c0  = cnt_q;
    if (a_q.op == OP_EVAL && a_q.stage == '0) begin
      r0 = '0; rj0 = 1'b0; c0 = '0;
    end
    sum = {r0[RespW-1], r0} + (RespW+1)'($signed(a_alpha_q));
    if (sum > $signed({1'b0, RespMax}))      sat = $signed(RespMax);
    else if (sum < $signed({1'b1, RespMin})) sat = $signed(RespMin);
    else                                     sat = sum[RespW-1:0];
    resp_d = resp_q;
    rej_d  = rej_q;
    cnt_d  = cnt_q;
    res    = '0;
    if (a_q.op == OP_EVAL) begin
      resp_d = r0; rej_d = rj0; cnt_d = c0;
      if (rj0 || c0 >= n_eff || {1'b0, a_q.stage} >= n_eff) begin
        res.window_done = rj0 || c0 >= n_eff;
      end else begin
        resp_d = sat;
        cnt_d  = c0 + 1'b1;
        rej_d  = sat < RespW'($signed(a_thr_q));
        res.feature_code = a_code_q;
        res.hypothesis   = a_alpha_q;
        res.window_done  = rej_d || cnt_d >= n_eff;
        res.detected     = res.window_done && !rej_d && sat > $signed(final_thr_i);
      end
    end
    res.response_sum = resp_d;
    res.rejected     = rej_d;
    res.stages_done  = cnt_d;
  end

endmodule

/* sv/boosted_cascade_stage_evaluator_unit.sv */
// Datapath: an accepted transaction passes the front register, queue, lookup
// register and result register before reaching the output ports; throughput one
// transaction per cycle while pop stays high, a held-off pop backs up into full.
// Reset (rst_ni low, asynchronous) clears pipeline valids, queue pointers,
// window state and registers to feature mode 0, stage count 64,
// final threshold 0; table memories are undefined until written.
`include "boosted_cascade_stage_evaluator_unit_macros.svh"
module boosted_cascade_stage_evaluator_unit import bcse_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  in_item_t    in_item_i,
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_item_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  mode_e             mode_q;
  logic [CountW-1:0] scount_q;
  logic [RespW-1:0]  fthr_q;
  logic              fq_push, q_full, q_valid, q_pop;
  work_t             fq_item, q_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_LBP;
      scount_q <= CountW'(64);
      fthr_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgFeatureMode:    mode_q   <= mode_e'(cfg_data_i[1:0]);
        CfgStageCount:     scount_q <= cfg_data_i[CountW-1:0];
        CfgFinalThreshold: fthr_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bcse_front u_front (
    .clk_i, .rst_ni,
    .push_i   (push),
    .full_o   (full),
    .item_i   (in_item_i),
    .q_full_i (q_full),
    .q_push_o (fq_push),
    .q_item_o (fq_item)
  );

  bcse_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (fq_push),
    .data_i  (fq_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_item)
  );

  bcse_back u_back (
    .clk_i, .rst_ni,
    .mode_i       (mode_q),
    .num_stages_i (scount_q),
    .final_thr_i  (fthr_q),
    .q_valid_i    (q_valid),
    .q_item_i     (q_item),
    .q_pop_o      (q_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .item_o       (out_item_o)
  );

  `BCSE_ASSERT_IMPL(a_det_done, !empty && out_item_o.detected, out_item_o.window_done && !out_item_o.rejected, "detect without clean completion")
  `BCSE_ASSERT_IMPL(a_cnt_max, !empty, out_item_o.stages_done <= CountW'(MaxStages), "stage count over limit")
  `BCSE_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(out_item_o), "result changed while stalled")

endmodule
